// ===== hw/rtl/ped_pkg.sv =====
// Shared types, constants and helpers for the percent-escape decoder.
// No dependencies; imported by every module of the block.
package ped_pkg;

    localparam logic [7:0] ESC_CHAR      = 8'h25;
    localparam int         QUEUE_DEPTH_D = 4;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIG   = 3'b100
    } t_phase;

    // One queue entry: the results of one input beat (none, one or two bytes).
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic       p0;
        logic [7:0] b1;
        logic       last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
               (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= "0" && c <= "9") begin
            v = c - 8'h30;
        end else if (c >= "a" && c <= "f") begin
            v = c - 8'h57;
        end else if (c >= "A" && c <= "F") begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

// ===== hw/rtl/ped_front.sv =====
// Front end: takes input beats, tracks escape state, builds queue entries.
// Depends on ped_pkg.
module ped_front import ped_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    output logic       o_push,
    output t_entry     o_entry
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       r_term, n_term;

    logic [1:0] cnt;
    logic [7:0] b0, b1;
    logic       do_plain;
    logic [7:0] pair;
    logic       b_hex;

    assign b_hex = is_hex(i_byte);
    assign pair  = {hex_val(r_held), hex_val(i_byte)};

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_term   = r_term;
        cnt      = 2'd0;
        b0       = 8'd0;
        b1       = 8'd0;
        do_plain = 1'b0;
        if (!r_term) begin
            case (r_phase)
                PH_PCT: begin
                    if (b_hex) begin
                        n_held  = i_byte;
                        n_phase = PH_DIG;
                    end else begin
                        n_phase  = PH_PLAIN;
                        do_plain = 1'b1;
                    end
                end
                PH_DIG: begin
                    n_phase = PH_PLAIN;
                    n_held  = 8'd0;
                    if (b_hex) begin
                        if (pair == 8'd0) begin
                            n_term = 1'b1;
                        end else begin
                            b0  = pair;
                            cnt = 2'd1;
                        end
                    end else begin
                        b0       = r_held;
                        cnt      = 2'd1;
                        do_plain = 1'b1;
                    end
                end
                default: begin
                    do_plain = 1'b1;
                end
            endcase
            if (do_plain) begin
                if (i_byte == 8'd0) begin
                    n_term  = 1'b1;
                    n_phase = PH_PLAIN;
                end else if (i_byte == ESC_CHAR) begin
                    n_phase = PH_PCT;
                end else begin
                    n_phase = PH_PLAIN;
                    if (cnt == 2'd0) begin
                        b0 = i_byte;
                    end else begin
                        b1 = i_byte;
                    end
                    cnt = cnt + 2'd1;
                end
            end
        end
        if (i_eos) begin
            // pending single digit is flushed as a plain byte
            if (!n_term && n_phase == PH_DIG) begin
                b0  = n_held;
                cnt = 2'd1;
            end
            n_phase = PH_PLAIN;
            n_held  = 8'd0;
            n_term  = 1'b0;
        end
    end

    assign o_push        = i_accept && (cnt != 2'd0 || i_eos);
    assign o_entry.two   = (cnt == 2'd2);
    assign o_entry.b0    = b0;
    assign o_entry.p0    = (cnt != 2'd0);
    assign o_entry.b1    = b1;
    assign o_entry.last  = i_eos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_held  <= 8'd0;
            r_term  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_term  <= n_term;
        end
    end

endmodule

// ===== hw/rtl/ped_queue.sv =====
// Small FIFO of decoded entries between front and back.
// Depends on ped_pkg.
module ped_queue import ped_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_D
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  t_entry                   i_entry,
    input  logic                     i_pop,
    output t_entry                   o_head,
    output t_q_status                o_status,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/ped_back.sv =====
// Back end: unpacks queue entries into output beats via an output register.
// Depends on ped_pkg.
module ped_back import ped_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_head,
    input  t_q_status i_status,
    output logic      o_pop,
    input  logic      i_ready,
    output logic      o_valid,
    output logic [7:0] o_data,
    output logic      o_user,
    output logic      o_last
);

    logic       r_sel;
    logic       r_valid;
    logic [7:0] r_data;
    logic       r_user;
    logic       r_last;
    logic       load, first_half;

    assign load       = (!r_valid || i_ready) && !i_status.empty;
    assign first_half = i_head.two && !r_sel;
    assign o_pop      = load && !first_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= first_half;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (first_half) begin
                r_data <= i_head.b0;
                r_user <= 1'b1;
                r_last <= 1'b0;
            end else if (r_sel) begin
                r_data <= i_head.b1;
                r_user <= 1'b1;
                r_last <= i_head.last;
            end else begin
                r_data <= i_head.b0;
                r_user <= i_head.p0;
                r_last <= i_head.last;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

endmodule

// ===== hw/rtl/percent_escape_decoder.sv =====
// Percent-escape decoder top: front classifier, entry queue, output back end.
// Path from input beat to first output beat: entry queue, then output register.
// Throughput: 1 input beat per cycle while the entry queue is not full; a beat giving
// two bytes holds the back end for both, absorbed by the entry queue (QUEUE_DEPTH entries).
// Reset: synchronous active-low i_rst_n clears escape state, queue and output valid.
module percent_escape_decoder import ped_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // end_of_string
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] byte_present
    output logic       m_axis_tlast    // last_of_string
);

    t_entry    w_entry, w_head;
    t_q_status w_status;
    logic      w_push, w_pop, w_accept;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] w_count;

    assign s_axis_tready = !w_status.full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    ped_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .i_eos    (s_axis_tlast),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    ped_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status),
        .o_count  (w_count)
    );

    ped_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_status (w_status),
        .o_pop    (w_pop),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_data   (m_axis_tdata),
        .o_user   (m_axis_tuser),
        .o_last   (m_axis_tlast)
    );

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_end_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tlast) |-> w_push)
        else $error("string end without queued result");

    a_bare_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("bare marker not at end of string");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

// ===== tb/sv/percent_escape_decoder_checker.sv =====
`timescale 1ns / 1ps
// Checker for percent_escape_decoder: watches both stream channels, decodes
// accepted input beats itself and compares every output beat. Needs ped_pkg.
module percent_escape_decoder_checker import ped_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,    // [7:0] in_byte
    input  logic       i_in_last,    // end_of_string
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,   // [7:0] out_byte
    input  logic       i_out_user,   // [0] byte_present
    input  logic       i_out_last,   // last_of_string
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } t_decoded;

    t_decoded   expected_bytes[$];
    t_decoded   beat_out[2];
    int         beat_cnt;

    t_phase     dec_phase;
    logic [7:0] held_digit;
    logic       truncated;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // {is_digit, nibble}
    function automatic logic [4:0] digit_info(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        beat_out[beat_cnt] = '{data: b, present: 1'b1, last: 1'b0};
        beat_cnt++;
    endtask

    task automatic plain_text(input logic [7:0] b);
        dec_phase = PH_PLAIN;
        if (b == 8'd0) begin
            truncated = 1'b1;
        end else if (b == ESC_CHAR) begin
            dec_phase = PH_PCT;
        end else begin
            add_byte(b);
        end
    endtask

    task automatic decode_beat(input logic [7:0] b, input logic eos);
        logic [4:0] lo;
        logic [4:0] hi;
        logic [7:0] value;
        beat_cnt = 0;
        lo = digit_info(b);
        if (!truncated) begin
            case (dec_phase)
                PH_PCT: begin
                    if (lo[4]) begin
                        held_digit = b;
                        dec_phase  = PH_DIG;
                    end else begin
                        plain_text(b);
                    end
                end
                PH_DIG: begin
                    if (lo[4]) begin
                        hi         = digit_info(held_digit);
                        value      = {hi[3:0], lo[3:0]};
                        dec_phase  = PH_PLAIN;
                        held_digit = 8'd0;
                        if (value == 8'd0) begin
                            truncated = 1'b1;
                        end else begin
                            add_byte(value);
                        end
                    end else begin
                        add_byte(held_digit);
                        held_digit = 8'd0;
                        plain_text(b);
                    end
                end
                default: plain_text(b);
            endcase
        end
        if (eos) begin
            if (!truncated && dec_phase == PH_DIG) begin
                add_byte(held_digit);
            end
            if (beat_cnt > 0) begin
                beat_out[beat_cnt-1].last = 1'b1;
            end else begin
                beat_out[0] = '{data: 8'd0, present: 1'b0, last: 1'b1};
                beat_cnt    = 1;
            end
            dec_phase  = PH_PLAIN;
            held_digit = 8'd0;
            truncated  = 1'b0;
        end
        for (int k = 0; k < beat_cnt; k++) begin
            expected_bytes.push_back(beat_out[k]);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ERROR %s: got 0x%02h, want 0x%02h", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_decoded head;
        if (!i_rst_n) begin
            dec_phase  = PH_PLAIN;
            held_digit = 8'd0;
            truncated  = 1'b0;
            expected_bytes.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                decode_beat(i_in_data, i_in_last);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected beat", i_out_data, 8'd0);
                end else begin
                    head = expected_bytes.pop_front();
                    if (i_out_data !== head.data) begin
                        report_mismatch("out_byte", i_out_data, head.data);
                    end
                    if (i_out_user !== head.present) begin
                        report_mismatch("byte_present", {7'd0, i_out_user},
                                        {7'd0, head.present});
                    end
                    if (i_out_last !== head.last) begin
                        report_mismatch("last_of_string", {7'd0, i_out_last},
                                        {7'd0, head.last});
                    end
                end
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the percent_escape_decoder testbench: clock, reset, escaped-string
// stimulus and output back-pressure. Needs the RTL and the checker module.
module tb_top;
    import ped_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int TARGET_BEATS = 1050;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] in_byte
    logic       s_axis_tlast;   // end_of_string
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic       m_axis_tuser;   // [0] byte_present
    logic       m_axis_tlast;   // last_of_string

    int   fail_count;
    int   pending;
    int   beats_sent;
    int   idle_cycles;
    int   stall_left;
    logic calm;

    percent_escape_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    percent_escape_decoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // mostly short gaps, a few long ones; none in calm stretches
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    initial begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = idle_length();
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic eos);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        beats_sent++;
        gap = idle_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_string(input logic [7:0] bytes[$]);
        foreach (bytes[k]) begin
            send_beat(bytes[k], k == bytes.size() - 1);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] hex_char();
        logic [3:0] n;
        n = 4'($urandom_range(0, 15));
        if (n < 10) begin
            return 8'h30 + n;
        end
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(8'h00, 8'h2f));
            1:       return 8'($urandom_range(8'h47, 8'h60));
            default: return 8'($urandom_range(8'h67, 8'hff));
        endcase
    endfunction

    task automatic random_string();
        logic [7:0] bytes[$];
        int         tokens;
        int         r;
        tokens = $urandom_range(1, 12);
        repeat (tokens) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                bytes.push_back(8'($urandom_range(1, 255)));
            end else if (r < 75) begin
                bytes.push_back(ESC_CHAR);
                bytes.push_back(hex_char());
                bytes.push_back(hex_char());
            end else if (r < 83) begin
                bytes.push_back(ESC_CHAR);
                bytes.push_back(hex_char());
                bytes.push_back(non_hex_char());
            end else if (r < 88) begin
                bytes.push_back(ESC_CHAR);
                bytes.push_back(non_hex_char());
            end else if (r < 92) begin
                bytes.push_back(8'h00);
            end else if (r < 95) begin
                bytes.push_back(ESC_CHAR);
                bytes.push_back(8'h30);
                bytes.push_back(8'h30);
            end else begin
                bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        // string cut inside an escape
        r = $urandom_range(0, 99);
        if (r < 6) begin
            bytes.push_back(ESC_CHAR);
        end else if (r < 12) begin
            bytes.push_back(ESC_CHAR);
            bytes.push_back(hex_char());
        end
        send_string(bytes);
    endtask

    initial begin
        int strings;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        beats_sent    = 0;
        idle_cycles   = 0;
        calm          = 1'b0;
        strings       = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_string('{ESC_CHAR, 8'h34, 8'h31});            // plain escape
        send_string('{ESC_CHAR, 8'h61, 8'h46});            // mixed case digits
        send_string('{ESC_CHAR, 8'h34, 8'h67});            // one digit then non-hex
        send_string('{ESC_CHAR, 8'h67});                   // no digit
        send_string('{ESC_CHAR, ESC_CHAR, 8'h34});         // double escape, end on digit
        send_string('{8'h01, 8'h00, 8'h41, 8'h42});        // raw zero truncates
        send_string('{ESC_CHAR, 8'h30, 8'h30});            // decoded zero
        send_string('{ESC_CHAR});                          // lone escape at end
        send_string('{ESC_CHAR, 8'h37});                   // end after one digit
        send_string('{8'hff});
        drain();

        while (beats_sent < TARGET_BEATS) begin
            if (strings % 20 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            random_string();
            strings++;
            if (strings == 40) begin
                drain();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
